FILE: src/route_path_candidate_scorer_macros.svh
// assertion helpers for the rtl files (included by rpcs_fifo)
`ifndef ROUTE_PATH_CANDIDATE_SCORER_MACROS_SVH
`define ROUTE_PATH_CANDIDATE_SCORER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define RPCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpcs assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define RPCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpcs assertion failed");

`endif

FILE: src/rpcs_pkg.sv
package rpcs_pkg;

  localparam int unsigned LenW    = 16;
  localparam int unsigned ClassW  = 4;
  localparam int unsigned SumW    = 24;
  localparam int unsigned UniW    = 7;
  localparam int unsigned ScoreW  = 9;
  localparam int unsigned QuotW   = 9;
  localparam int unsigned NumW    = SumW + QuotW;

  localparam logic [UniW-1:0] UniClassSame = 7'd40;
  localparam logic [UniW-1:0] UniClassNear = 7'd15;
  localparam logic [UniW-1:0] UniOneWay    = 7'd17;
  localparam logic [UniW-1:0] UniRoundabt  = 7'd18;
  localparam logic [UniW-1:0] UniLinkRoad  = 7'd10;

  localparam logic [8:0] ScoreNumMul = 9'd275;
  localparam logic [7:0] ScoreDenMul = 8'd165;
  localparam logic signed [ScoreW:0] ScoreOffset = 10'sd165;
  localparam logic signed [ScoreW-1:0] ScoreMatch = 9'sd110;

  typedef struct packed {
    logic [SumW-1:0] len_sum;
    logic [LenW-1:0] target;
    logic            many_edges;
    logic [UniW-1:0] uni_score;
  } job_t;

endpackage

FILE: src/rpcs_accum.sv
module rpcs_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          edge_valid_i,
  input  logic [rpcs_pkg::LenW-1:0]     edge_length_i,
  input  logic [rpcs_pkg::ClassW-1:0]   road_class_i,
  input  logic                          one_way_i,
  input  logic                          roundabout_i,
  input  logic                          link_road_i,
  input  logic [rpcs_pkg::LenW-1:0]     target_length_i,
  input  logic                          last_edge_i,
  input  logic                          queue_full_i,
  output logic                          edge_ready_o,
  output logic                          job_push_o,
  output rpcs_pkg::job_t                job_o
);
  import rpcs_pkg::*;

  logic [1:0]        count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ClassW-1:0] min_q, min_d, max_q, max_d;
  logic [2:0]        first_q, first_d, same_q, same_d;
  logic [2:0]        flags;
  logic [SumW:0]     sum_wide;
  logic [ClassW-1:0] diff;
  logic [UniW-1:0]   uni;
  logic              take;

  assign edge_ready_o = !queue_full_i;
  assign take         = edge_valid_i && edge_ready_o;
  assign flags        = {link_road_i, roundabout_i, one_way_i};
  assign sum_wide     = {1'b0, sum_q} + {{(SumW+1-LenW){1'b0}}, edge_length_i};

  always_comb begin
    sum_d = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
    count_d = (count_q == 2'd3) ? count_q : count_q + 2'd1;
    if (count_q == 2'd0) begin
      min_d   = road_class_i;
      max_d   = road_class_i;
      first_d = flags;
      same_d  = same_q;
    end else begin
      min_d   = (road_class_i < min_q) ? road_class_i : min_q;
      max_d   = (road_class_i > max_q) ? road_class_i : max_q;
      first_d = first_q;
      same_d  = same_q & ~(first_q ^ flags);
    end
    diff = max_d - min_d;
    uni  = (diff == '0) ? UniClassSame : ((diff == 4'd1) ? UniClassNear : '0);
    if (same_d[0]) uni = uni + UniOneWay;
    if (same_d[1]) uni = uni + UniRoundabt;
    if (same_d[2]) uni = uni + UniLinkRoad;
  end

  assign job_push_o       = take && last_edge_i;
  assign job_o.len_sum    = sum_d;
  assign job_o.target     = target_length_i;
  assign job_o.many_edges = (count_d == 2'd3);
  assign job_o.uni_score  = uni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      first_q <= '0;
      same_q  <= '1;
    end else if (take) begin
      if (last_edge_i) begin
        count_q <= '0;
        sum_q   <= '0;
        min_q   <= '0;
        max_q   <= '0;
        first_q <= '0;
        same_q  <= '1;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        min_q   <= min_d;
        max_q   <= max_d;
        first_q <= first_d;
        same_q  <= same_d;
      end
    end
  end

endmodule

FILE: src/rpcs_fifo.sv
`include "route_path_candidate_scorer_macros.svh"

module rpcs_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  rpcs_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           rd_valid_o,
  output rpcs_pkg::job_t rd_data_o
);
  import rpcs_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_en_i && !full_o;
  assign pop        = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `RPCS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(Depth))
  `RPCS_ASSERT_NXT(a_count_inc, push && !pop, count_q == $past(count_q) + 1'b1)
  `RPCS_ASSERT_IMP(a_no_pop_empty, rd_en_i, count_q != '0)

endmodule

FILE: src/rpcs_score.sv
module rpcs_score (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  rpcs_pkg::job_t                     job_i,
  output logic                               job_pop_o,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic                               path_valid_o,
  output logic signed [rpcs_pkg::ScoreW-1:0] length_score_o,
  output logic        [rpcs_pkg::UniW-1:0]   uniformity_score_o,
  output logic signed [rpcs_pkg::ScoreW-1:0] total_score_o
);
  import rpcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e            state_q;
  job_t              job_q;
  logic [SumW-1:0]   mn_q, mx_q, rem_q;
  logic [NumW-1:0]   num_q, den_q;
  logic [QuotW-1:0]  lo_q, quot_q;
  logic [3:0]        step_q;
  logic              le_q;
  logic              out_free;
  logic [SumW:0]     rem_sh, rem_sub;
  logic              q_bit;
  logic              mx_zero, ok;
  logic signed [ScoreW:0]   raw;
  logic signed [ScoreW-1:0] lscore;

  assign out_free  = !res_valid_o || res_ready_i;
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  assign rem_sh  = {rem_q, lo_q[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, mx_q};
  assign q_bit   = (rem_sh >= {1'b0, mx_q});

  always_comb begin
    mx_zero = (mx_q == '0);
    ok      = mx_zero || !(le_q && job_q.many_edges);
    raw     = $signed({1'b0, quot_q}) - ScoreOffset
            + $signed({{ScoreW{1'b0}}, (!le_q || rem_q == '0) ? 1'b0 : 1'b1});
    lscore  = mx_zero ? ScoreMatch : raw[ScoreW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      job_q              <= '0;
      mn_q               <= '0;
      mx_q               <= '0;
      rem_q              <= '0;
      num_q              <= '0;
      den_q              <= '0;
      lo_q               <= '0;
      quot_q             <= '0;
      step_q             <= '0;
      le_q               <= 1'b0;
      res_valid_o        <= 1'b0;
      path_valid_o       <= 1'b0;
      length_score_o     <= '0;
      uniformity_score_o <= '0;
      total_score_o      <= '0;
    end else begin
      if (res_valid_o && res_ready_i && state_q != ST_OUT) begin
        res_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if ({8'd0, job_q.target} < job_q.len_sum) begin
            mn_q <= {8'd0, job_q.target};
            mx_q <= job_q.len_sum;
          end else begin
            mn_q <= job_q.len_sum;
            mx_q <= {8'd0, job_q.target};
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          num_q   <= {{QuotW{1'b0}}, mn_q} * NumW'(ScoreNumMul);
          den_q   <= {{QuotW{1'b0}}, mx_q} * NumW'(ScoreDenMul);
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          rem_q   <= num_q[NumW-1:QuotW];
          lo_q    <= num_q[QuotW-1:0];
          le_q    <= (num_q <= den_q);
          quot_q  <= '0;
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= q_bit ? rem_sub[SumW-1:0] : rem_sh[SumW-1:0];
          lo_q   <= {lo_q[QuotW-2:0], 1'b0};
          quot_q <= {quot_q[QuotW-2:0], q_bit};
          step_q <= step_q + 4'd1;
          if (step_q == 4'(QuotW - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_valid_o        <= 1'b1;
            path_valid_o       <= ok;
            length_score_o     <= ok ? lscore : '0;
            uniformity_score_o <= job_q.uni_score;
            total_score_o      <= ok ? lscore + $signed({2'b00, job_q.uni_score}) : '0;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/route_path_candidate_scorer.sv
// route path candidate scorer
// slave stream carries one road edge per beat; tlast marks the final edge of
// a path. tdata: edge_length, road_class, one_way, roundabout, link_road,
// target_length (target is taken from the final beat only).
// master stream carries one score beat per path: path_valid, length_score,
// uniformity_score, total_score.
// edges are accumulated at one beat per cycle by the front end while the
// job queue is not full; the final edge pushes a job into a small queue
// (QueueDepth entries). the back end takes one job at a time: compare,
// constant multiplies, a load step, a nine-step restoring divider and a
// result stage.
// s_axis_tready drops only while the job queue is full.
// the result register holds its beat while m_axis_tready is low; the back
// end then waits with its next job and the queue fills behind it.
// reset clears the running path state, the queue and the result register.
module route_path_candidate_scorer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // edge_length[15:0], road_class[19:16], one_way[20], roundabout[21],
  // link_road[22], target_length[38:23], zero fill[39]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // path_valid[0], length_score[9:1], uniformity_score[16:10],
  // total_score[25:17], zero fill[31:26]
  output logic [31:0] m_axis_tdata
);
  import rpcs_pkg::*;

  job_t                     push_job, pop_job;
  logic                     push, full, pop, pop_valid;
  logic                     path_valid;
  logic signed [ScoreW-1:0] length_score, total_score;
  logic [UniW-1:0]          uniformity_score;

  rpcs_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .edge_valid_i    (s_axis_tvalid),
    .edge_length_i   (s_axis_tdata[15:0]),
    .road_class_i    (s_axis_tdata[19:16]),
    .one_way_i       (s_axis_tdata[20]),
    .roundabout_i    (s_axis_tdata[21]),
    .link_road_i     (s_axis_tdata[22]),
    .target_length_i (s_axis_tdata[38:23]),
    .last_edge_i     (s_axis_tlast),
    .queue_full_i    (full),
    .edge_ready_o    (s_axis_tready),
    .job_push_o      (push),
    .job_o           (push_job)
  );

  rpcs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (push_job),
    .full_o     (full),
    .rd_en_i    (pop),
    .rd_valid_o (pop_valid),
    .rd_data_o  (pop_job)
  );

  rpcs_score u_score (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (pop_valid),
    .job_i              (pop_job),
    .job_pop_o          (pop),
    .res_valid_o        (m_axis_tvalid),
    .res_ready_i        (m_axis_tready),
    .path_valid_o       (path_valid),
    .length_score_o     (length_score),
    .uniformity_score_o (uniformity_score),
    .total_score_o      (total_score)
  );

  assign m_axis_tdata = {6'd0, total_score, uniformity_score, length_score, path_valid};

endmodule
